/* hw/rtl/pdt_pkg.sv */
// Shared types, constants and the rotation term table of the proximity dwell trigger.
package pdt_pkg;

    localparam int PDT_TIME_BITS = 48;
    // Fraction bits of a rotation matrix entry (Q3.28).
    localparam int PDT_QFRAC2    = 28;

    typedef struct packed {
        logic signed [31:0]              vehicle_x;
        logic signed [31:0]              vehicle_y;
        logic signed [31:0]              vehicle_z;
        logic signed [15:0]              quat_w;
        logic signed [15:0]              quat_x;
        logic signed [15:0]              quat_y;
        logic signed [15:0]              quat_z;
        logic signed [31:0]              target_x;
        logic signed [31:0]              target_y;
        logic signed [31:0]              target_z;
        logic        [PDT_TIME_BITS-1:0] time_now;
    } t_in_item;

    typedef struct packed {
        logic        activate;
        logic        inside_res;
        logic [63:0] distance_sq;
    } t_out_item;

    typedef enum logic [2:0] {
        CFG_DISTANCE_LIMIT = 3'd0,
        CFG_MIN_DWELL      = 3'd1,
        CFG_OFFSET_X       = 3'd2,
        CFG_OFFSET_Y       = 3'd3,
        CFG_OFFSET_Z       = 3'd4
    } t_cfg_reg;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ISSUE = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_ROW   = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        PH_ROT = 2'd0,
        PH_SQ  = 2'd1,
        PH_LIM = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        Q_W = 2'd0,
        Q_X = 2'd1,
        Q_Y = 2'd2,
        Q_Z = 2'd3
    } t_qsel;

    typedef struct packed {
        t_qsel p;
        t_qsel q;
        logic  neg;
    } t_qterm;

    // One of the two quaternion products of matrix entry (row, col): +-2*p*q.
    function automatic t_qterm pdt_qterm(input logic [1:0] row, input logic [1:0] col,
                                         input logic sub);
        t_qterm t;
        t = '{p: Q_W, q: Q_W, neg: 1'b0};
        unique case ({row, col, sub})
            5'b00_00_0: t = '{p: Q_Y, q: Q_Y, neg: 1'b1};
            5'b00_00_1: t = '{p: Q_Z, q: Q_Z, neg: 1'b1};
            5'b00_01_0: t = '{p: Q_X, q: Q_Y, neg: 1'b0};
            5'b00_01_1: t = '{p: Q_W, q: Q_Z, neg: 1'b1};
            5'b00_10_0: t = '{p: Q_X, q: Q_Z, neg: 1'b0};
            5'b00_10_1: t = '{p: Q_W, q: Q_Y, neg: 1'b0};
            5'b01_00_0: t = '{p: Q_X, q: Q_Y, neg: 1'b0};
            5'b01_00_1: t = '{p: Q_W, q: Q_Z, neg: 1'b0};
            5'b01_01_0: t = '{p: Q_X, q: Q_X, neg: 1'b1};
            5'b01_01_1: t = '{p: Q_Z, q: Q_Z, neg: 1'b1};
            5'b01_10_0: t = '{p: Q_Y, q: Q_Z, neg: 1'b0};
            5'b01_10_1: t = '{p: Q_W, q: Q_X, neg: 1'b1};
            5'b10_00_0: t = '{p: Q_X, q: Q_Z, neg: 1'b0};
            5'b10_00_1: t = '{p: Q_W, q: Q_Y, neg: 1'b1};
            5'b10_01_0: t = '{p: Q_Y, q: Q_Z, neg: 1'b0};
            5'b10_01_1: t = '{p: Q_W, q: Q_X, neg: 1'b0};
            5'b10_10_0: t = '{p: Q_X, q: Q_X, neg: 1'b1};
            5'b10_10_1: t = '{p: Q_Y, q: Q_Y, neg: 1'b1};
            default:    t = '{p: Q_W, q: Q_W, neg: 1'b0};
        endcase
        return t;
    endfunction

endpackage

/* hw/rtl/pdt_ifs.sv */
// Handshake channel interfaces: input items, result items and register writes.
interface pdt_in_if;
    import pdt_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pdt_out_if;
    import pdt_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pdt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/pdt_smul.sv */
// Bit-serial signed multiplier: one multiplier bit per cycle, top bit subtracted.
module pdt_smul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic        [4:0]  i_last,
    output logic               o_done,
    output logic signed [64:0] o_prod
);
    logic               r_busy, r_done;
    logic        [4:0]  r_cnt;
    logic signed [64:0] r_a;
    logic        [31:0] r_b;
    logic signed [64:0] r_p;
    logic signed [64:0] term;

    assign term = r_b[0] ? r_a : '0;

    // Control: run from start until the sign bit of the multiplier is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == i_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift multiplicand left, multiplier right, accumulate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= 65'(i_a);
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_a <= r_a <<< 1;
            r_b <= r_b >> 1;
            r_p <= (r_cnt == i_last) ? (r_p - term) : (r_p + term);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("multiplier done without run");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("multiplier restarted while busy");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= i_last)) else $error("multiplier count overran");
endmodule

/* hw/rtl/proximity_dwell_trigger.sv */
// Top level: rotate offset, measure squared distance, time dwell and fire once.
//
//  channel  | modport | transfers
//  ---------+---------+------------------------------------------------
//  i_in     | sink    | one position/orientation/target/time item
//  o_out    | source  | activate, inside_res, distance_sq per item
//  i_cfg    | sink    | register index and data, always ready
//
// Each item needs 31 products that go one after another through one bit-serial
// multiplier (18 of 16 bits, 13 of 32 bits, each with an issue and a hand-off
// state), plus a row step for each of the three rows and an output step.
// i_in is ready only while idle; a finished result waits in the output register
// and a new item is taken meanwhile. Reset clears config registers and dwell state.
module proximity_dwell_trigger (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdt_in_if.sink      i_in,
    pdt_out_if.source   o_out,
    pdt_cfg_if.sink     i_cfg
);
    import pdt_pkg::*;

    t_state             r_state;
    t_phase             r_phase;
    logic        [1:0]  r_ri, r_ci, r_sub;
    t_in_item           r_item;
    logic        [30:0] r_lim;
    logic [PDT_TIME_BITS-1:0] r_dwell;
    logic signed [31:0] r_off [3];
    logic signed [31:0] r_d [3];
    logic signed [34:0] r_ent;
    logic signed [63:0] r_acc;
    logic        [63:0] r_dsq;
    logic               r_ev, r_fired, r_act, r_inside;
    logic [PDT_TIME_BITS-1:0] r_et;
    logic               r_ov;
    t_out_item          r_out;

    logic               mul_start, mul_done;
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic        [4:0]  mul_last;
    logic signed [64:0] mul_prod;

    t_qterm             qt;
    logic signed [15:0] qp, qq;
    logic signed [32:0] twop;
    logic signed [30:0] ent_clamp;
    logic signed [63:0] row_sum;
    logic signed [63-PDT_QFRAC2:0] row_rnd;
    logic signed [31:0] vsel, tsel;
    logic signed [36:0] pnt;
    logic signed [37:0] dif;
    logic signed [31:0] dsat;
    logic [PDT_TIME_BITS-1:0] et_n;
    logic               near_hit;

    function automatic logic signed [15:0] qval(input t_qsel s, input t_in_item it);
        logic signed [15:0] v;
        unique case (s)
            Q_W:     v = it.quat_w;
            Q_X:     v = it.quat_x;
            Q_Y:     v = it.quat_y;
            default: v = it.quat_z;
        endcase
        return v;
    endfunction

    pdt_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_last  (mul_last),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;
    assign mul_start   = (r_state == ST_ISSUE);

    // Pick multiplier operands for the current product
    always_comb begin
        qt   = pdt_qterm(r_ri, r_ci, r_sub[0]);
        qp   = qval(qt.p, r_item);
        qq   = qval(qt.q, r_item);
        twop = 33'(qp) <<< 1;
        if (r_ent > 35'sd536870912)       ent_clamp = 31'sd536870912;
        else if (r_ent < -35'sd536870912) ent_clamp = -31'sd536870912;
        else                              ent_clamp = r_ent[30:0];
        unique case (r_phase)
            PH_ROT: begin
                if (r_sub == 2'd2) begin
                    mul_a    = 33'(ent_clamp);
                    mul_b    = r_off[r_ci];
                    mul_last = 5'd31;
                end else begin
                    mul_a    = qt.neg ? -twop : twop;
                    mul_b    = 32'(qq);
                    mul_last = 5'd15;
                end
            end
            PH_SQ: begin
                mul_a    = 33'(r_d[r_ri]);
                mul_b    = r_d[r_ri];
                mul_last = 5'd31;
            end
            default: begin
                mul_a    = 33'({1'b0, r_lim});
                mul_b    = 32'({1'b0, r_lim});
                mul_last = 5'd31;
            end
        endcase
    end

    // Finish one row: round, add vehicle, subtract from target, saturate
    always_comb begin
        unique case (r_ri)
            2'd0:    begin vsel = r_item.vehicle_x; tsel = r_item.target_x; end
            2'd1:    begin vsel = r_item.vehicle_y; tsel = r_item.target_y; end
            default: begin vsel = r_item.vehicle_z; tsel = r_item.target_z; end
        endcase
        row_sum = r_acc + (64'sd1 <<< (PDT_QFRAC2 - 1));
        row_rnd = row_sum[63:PDT_QFRAC2];
        pnt     = 37'(vsel) + 37'(row_rnd);
        dif     = 38'(tsel) - 38'(pnt);
        if (dif > 38'sd2147483647)       dsat = 32'sh7FFFFFFF;
        else if (dif < -38'sd2147483648) dsat = 32'sh80000000;
        else                             dsat = dif[31:0];
    end

    // Dwell decision from the limit product
    always_comb begin
        near_hit = r_dsq < mul_prod[63:0];
        et_n     = (!r_ev || (r_item.time_now < r_et)) ? r_item.time_now : r_et;
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim   <= '0;
            r_dwell <= '0;
            r_off   <= '{default: '0};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DISTANCE_LIMIT: r_lim    <= i_cfg.data[30:0];
                CFG_MIN_DWELL:      r_dwell  <= i_cfg.data[PDT_TIME_BITS-1:0];
                CFG_OFFSET_X:       r_off[0] <= i_cfg.data[31:0];
                CFG_OFFSET_Y:       r_off[1] <= i_cfg.data[31:0];
                CFG_OFFSET_Z:       r_off[2] <= i_cfg.data[31:0];
                default: ;
            endcase
        end
    end

    // Sequence the products and hold dwell state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_ROT;
            r_ri    <= '0;
            r_ci    <= '0;
            r_sub   <= '0;
            r_ev    <= 1'b0;
            r_et    <= '0;
            r_fired <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            // Drop the result once taken, unless a new one is loaded below
            if (r_ov && o_out.ready && (r_state != ST_DONE)) r_ov <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_item  <= i_in.data;
                        r_phase <= PH_ROT;
                        r_ri    <= '0;
                        r_ci    <= '0;
                        r_sub   <= '0;
                        r_acc   <= '0;
                        r_dsq   <= '0;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (r_phase == PH_ROT && r_sub == 2'd0)
                        r_ent <= (r_ri == r_ci) ? (35'sd1 <<< PDT_QFRAC2) : '0;
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mul_done) begin
                        unique case (r_phase)
                            PH_ROT: begin
                                r_state <= ST_ISSUE;
                                if (r_sub != 2'd2) begin
                                    r_ent <= r_ent + mul_prod[34:0];
                                    r_sub <= r_sub + 2'd1;
                                end else begin
                                    r_acc <= r_acc + mul_prod[63:0];
                                    r_sub <= '0;
                                    if (r_ci == 2'd2) begin
                                        r_ci    <= '0;
                                        r_state <= ST_ROW;
                                    end else begin
                                        r_ci <= r_ci + 2'd1;
                                    end
                                end
                            end
                            PH_SQ: begin
                                r_dsq   <= r_dsq + mul_prod[63:0];
                                r_state <= ST_ISSUE;
                                if (r_ri == 2'd2) begin
                                    r_ri    <= '0;
                                    r_phase <= PH_LIM;
                                end else begin
                                    r_ri <= r_ri + 2'd1;
                                end
                            end
                            default: begin
                                r_inside <= near_hit;
                                r_act    <= 1'b0;
                                if (near_hit) begin
                                    if (!r_fired) begin
                                        r_ev <= 1'b1;
                                        r_et <= et_n;
                                        if ((r_item.time_now - et_n) >= r_dwell) begin
                                            r_fired <= 1'b1;
                                            r_act   <= 1'b1;
                                        end
                                    end
                                end else begin
                                    r_ev    <= 1'b0;
                                    r_et    <= '0;
                                    r_fired <= 1'b0;
                                end
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_ROW: begin
                    r_d[r_ri] <= dsat;
                    r_acc     <= '0;
                    r_state   <= ST_ISSUE;
                    if (r_ri == 2'd2) begin
                        r_ri    <= '0;
                        r_phase <= PH_SQ;
                    end else begin
                        r_ri <= r_ri + 2'd1;
                    end
                end
                default: begin
                    // Hand the result over once the output register is free
                    if (!r_ov || o_out.ready) begin
                        r_out   <= '{activate: r_act, inside_res: r_inside,
                                     distance_sq: r_dsq};
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    a_fired_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fired |-> r_ev) else $error("fired without entry record");
    a_entry_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ev |-> (r_et == '0)) else $error("entry time kept after leaving");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_WAIT)) else $error("product arrived outside wait");
    a_accept_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ST_ISSUE))
        else $error("accepted item not started");
    a_act_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.activate) |-> r_out.inside_res)
        else $error("activate outside threshold");
endmodule
